>>> sv/vctm_pkg.sv
// ----------------------------------------------------------------------------
// vctm_pkg
// Shared types, codes and helpers for the voxel dilation and erosion block.
// ----------------------------------------------------------------------------
package vctm_pkg;

    localparam int DEF_MAX_X      = 64;
    localparam int DEF_MAX_Y      = 64;
    localparam int DEF_MAX_Z      = 64;
    localparam int DEF_MAX_RADIUS = 8;

    localparam int POS_W    = 6;
    localparam int SIZE_W   = 7;
    localparam int RAD_W    = 4;
    localparam int THR_W    = 13;
    localparam int VOX_W    = 8;
    localparam int SUM_W    = 8;
    localparam int CFG_IX_W = 3;
    localparam int CFG_D_W  = 13;

    localparam logic [VOX_W-1:0] FULL_VALUE = 8'd255;

    localparam logic MODE_DILATE = 1'b0;
    localparam logic MODE_ERODE  = 1'b1;

    localparam logic CMD_WRITE   = 1'b0;
    localparam logic CMD_COMPUTE = 1'b1;

    typedef enum logic [CFG_IX_W-1:0] {
        CFG_MODE      = 3'd0,
        CFG_X_SIZE    = 3'd1,
        CFG_Y_SIZE    = 3'd2,
        CFG_Z_SIZE    = 3'd3,
        CFG_RADIUS    = 3'd4,
        CFG_THRESHOLD = 3'd5
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CENTER,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // Configuration as seen by the engine, with sizes and radius saturated.
    typedef struct packed {
        logic              mode;
        logic [SIZE_W-1:0] x_size;
        logic [SIZE_W-1:0] y_size;
        logic [SIZE_W-1:0] z_size;
        logic [RAD_W-1:0]  radius;
        logic [THR_W-1:0]  threshold;
    } vctm_cfg_t;

    typedef struct packed {
        logic             we;
        logic [VOX_W-1:0] wdata;
    } vctm_mem_req_t;

    function automatic logic [SIZE_W-1:0] clamp_coord(
        input logic signed [SUM_W-1:0] c,
        input logic        [SIZE_W-1:0] size
    );
        logic [SIZE_W-1:0] res;
        if (c < 0)
        begin
            res = '0;
        end
        else if (c >= $signed(SUM_W'(size)))
        begin
            res = size - SIZE_W'(1);
        end
        else
        begin
            res = c[SIZE_W-1:0];
        end
        return res;
    endfunction

endpackage

>>> sv/vctm_ram.sv
// ----------------------------------------------------------------------------
// vctm_ram
// Single-port voxel memory with a registered read, one access per cycle.
// ----------------------------------------------------------------------------
module vctm_ram
    import vctm_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_X * DEF_MAX_Y * DEF_MAX_Z,
    parameter int AW    = 18
)
(
    input  logic             clk,
    input  vctm_mem_req_t    req,
    input  logic [AW-1:0]    addr,
    output logic [VOX_W-1:0] rdata
);

    logic [VOX_W-1:0] mem [DEPTH];
    logic [VOX_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[addr] <= req.wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/vctm_engine.sv
// ----------------------------------------------------------------------------
// vctm_engine
// Sequencer that stores voxels, reads the centre voxel, sweeps the window
// through the memory one voxel a cycle and forms the result.
// ----------------------------------------------------------------------------
module vctm_engine
    import vctm_pkg::*;
#(
    parameter int MAX_X      = DEF_MAX_X,
    parameter int MAX_Y      = DEF_MAX_Y,
    parameter int MAX_Z      = DEF_MAX_Z,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS,
    parameter int AW         = 18
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  vctm_cfg_t         cfg,
    input  logic              start,
    input  logic              command,
    input  logic [POS_W-1:0]  pos_x,
    input  logic [POS_W-1:0]  pos_y,
    input  logic [POS_W-1:0]  pos_z,
    input  logic [VOX_W-1:0]  voxel_value,
    output logic              busy,
    output logic              done,
    output logic [VOX_W-1:0]  result_value,
    output vctm_mem_req_t     mem_req,
    output logic [AW-1:0]     mem_addr,
    input  logic [VOX_W-1:0]  mem_rdata
);

    localparam int RMAX    = (MAX_RADIUS < 15) ? MAX_RADIUS : 15;
    localparam int OW      = $clog2(MAX_RADIUS + 1) + 1;
    localparam int CNT_MAX = (2 * RMAX) * (2 * RMAX) * (2 * RMAX);
    localparam int CNTW    = $clog2(CNT_MAX + 1);
    localparam int CMPW    = (CNTW > THR_W) ? CNTW : THR_W;

    state_t state_reg, state_next;

    logic signed [OW-1:0] off_x_reg, off_x_next;
    logic signed [OW-1:0] off_y_reg, off_y_next;
    logic signed [OW-1:0] off_z_reg, off_z_next;
    logic [CNTW-1:0]      count_reg, count_next;
    logic                 pend_reg, pend_next;
    logic                 done_reg, done_next;
    logic [VOX_W-1:0]     result_reg, result_next;
    logic [VOX_W-1:0]     cur_reg;
    logic [POS_W-1:0]     px_reg, py_reg, pz_reg;

    logic                 accept;
    logic                 in_range;
    logic signed [OW-1:0] rad_s, rad_neg, rad_last;
    logic [POS_W-1:0]     sel_x, sel_y, sel_z;
    logic signed [OW-1:0] sel_ox, sel_oy, sel_oz;
    logic [SIZE_W-1:0]    cx, cy, cz;
    logic [31:0]          addr_full;
    logic [CMPW-1:0]      count_cmp, thr_cmp;

    assign accept   = start && (state_reg == ST_IDLE);
    assign in_range = ({1'b0, pos_x} < cfg.x_size) && ({1'b0, pos_y} < cfg.y_size)
                      && ({1'b0, pos_z} < cfg.z_size);

    assign rad_s    = OW'($signed({1'b0, cfg.radius}));
    assign rad_neg  = -rad_s;
    assign rad_last = rad_s - OW'(1);

    assign sel_x  = (state_reg == ST_IDLE) ? pos_x : px_reg;
    assign sel_y  = (state_reg == ST_IDLE) ? pos_y : py_reg;
    assign sel_z  = (state_reg == ST_IDLE) ? pos_z : pz_reg;
    assign sel_ox = (state_reg == ST_IDLE) ? '0 : off_x_reg;
    assign sel_oy = (state_reg == ST_IDLE) ? '0 : off_y_reg;
    assign sel_oz = (state_reg == ST_IDLE) ? '0 : off_z_reg;

    assign cx = clamp_coord($signed(SUM_W'(sel_x)) + SUM_W'(sel_ox), cfg.x_size);
    assign cy = clamp_coord($signed(SUM_W'(sel_y)) + SUM_W'(sel_oy), cfg.y_size);
    assign cz = clamp_coord($signed(SUM_W'(sel_z)) + SUM_W'(sel_oz), cfg.z_size);

    assign addr_full = 32'((32'(cz) * MAX_Y + 32'(cy)) * MAX_X + 32'(cx));
    assign mem_addr  = addr_full[AW-1:0];

    assign mem_req.we    = accept && in_range && (command == CMD_WRITE);
    assign mem_req.wdata = voxel_value;

    assign count_cmp = CMPW'(count_reg);
    assign thr_cmp   = CMPW'(cfg.threshold);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            off_x_reg  <= '0;
            off_y_reg  <= '0;
            off_z_reg  <= '0;
            count_reg  <= '0;
            pend_reg   <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            off_x_reg  <= off_x_next;
            off_y_reg  <= off_y_next;
            off_z_reg  <= off_z_next;
            count_reg  <= count_next;
            pend_reg   <= pend_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (accept)
        begin
            px_reg <= pos_x;
            py_reg <= pos_y;
            pz_reg <= pos_z;
        end
        if (state_reg == ST_CENTER)
        begin
            cur_reg <= mem_rdata;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        off_x_next  = off_x_reg;
        off_y_next  = off_y_reg;
        off_z_next  = off_z_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        pend_next   = (state_reg == ST_SCAN);
        count_next  = count_reg + CNTW'(pend_reg && (mem_rdata != '0));

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_range && (command == CMD_COMPUTE))
                begin
                    count_next = '0;
                    state_next = ST_CENTER;
                end
            end
            ST_CENTER:
            begin
                if ((cfg.mode == MODE_ERODE) && (mem_rdata == '0))
                begin
                    result_next = '0;
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
                else if ((cfg.mode == MODE_DILATE) && (mem_rdata != '0))
                begin
                    result_next = mem_rdata;
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
                else if (cfg.radius == '0)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    off_x_next = rad_neg;
                    off_y_next = rad_neg;
                    off_z_next = rad_neg;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (off_x_reg == rad_last)
                begin
                    off_x_next = rad_neg;
                    if (off_y_reg == rad_last)
                    begin
                        off_y_next = rad_neg;
                        if (off_z_reg == rad_last)
                        begin
                            state_next = ST_DRAIN;
                        end
                        else
                        begin
                            off_z_next = off_z_reg + OW'(1);
                        end
                    end
                    else
                    begin
                        off_y_next = off_y_reg + OW'(1);
                    end
                end
                else
                begin
                    off_x_next = off_x_reg + OW'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (cfg.mode == MODE_DILATE)
                begin
                    result_next = (count_cmp >= thr_cmp) ? FULL_VALUE : '0;
                end
                else
                begin
                    result_next = (count_cmp <= thr_cmp) ? '0 : cur_reg;
                end
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign result_value = result_reg;

endmodule

>>> sv/volume_count_threshold_morphology.sv
// ----------------------------------------------------------------------------
// volume_count_threshold_morphology
// Three-dimensional dilation and erosion of an 8-bit voxel volume.
// ----------------------------------------------------------------------------
// An input transaction is taken at a rising edge with start high and busy low.
// A write transaction stores voxel_value at the given position in that cycle
// and leaves busy low, so writes may follow one another every cycle.
// A compute transaction reads the centre voxel, and when the mode decides the
// value from that voxel alone, done pulses on leaving the centre state.
// Otherwise the window of (2r)^3 voxels is read through the single memory
// port, one voxel per cycle, in the scan and drain states, and done pulses
// on leaving the finish state; busy is high from acceptance until then.
// result_value is valid during the single cycle in which done is high; the
// receiver cannot stall it, and a new transaction may be taken in that cycle.
// Positions outside the configured size are accepted and dropped.
// Configuration is written through cfg_write, cfg_index and cfg_data while
// the block is idle (user rule, unenforced). Reset restores register defaults;
// the voxel memory is not cleared and must be written before it is read.
// ----------------------------------------------------------------------------
module volume_count_threshold_morphology
    import vctm_pkg::*;
#(
    parameter int MAX_X      = DEF_MAX_X,
    parameter int MAX_Y      = DEF_MAX_Y,
    parameter int MAX_Z      = DEF_MAX_Z,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [CFG_IX_W-1:0] cfg_index,
    input  logic [CFG_D_W-1:0]  cfg_data,
    input  logic                start,
    output logic                busy,
    input  logic                command,
    input  logic [POS_W-1:0]    pos_x,
    input  logic [POS_W-1:0]    pos_y,
    input  logic [POS_W-1:0]    pos_z,
    input  logic [VOX_W-1:0]    voxel_value,
    output logic                done,
    output logic [VOX_W-1:0]    result_value
);

    localparam int DEPTH = MAX_X * MAX_Y * MAX_Z;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic              mode_reg;
    logic [SIZE_W-1:0] x_size_reg, y_size_reg, z_size_reg;
    logic [RAD_W-1:0]  radius_reg;
    logic [THR_W-1:0]  threshold_reg;

    vctm_cfg_t         cfg;
    vctm_mem_req_t     mem_req;
    logic [AW-1:0]     mem_addr;
    logic [VOX_W-1:0]  mem_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_DILATE;
            x_size_reg    <= SIZE_W'(64);
            y_size_reg    <= SIZE_W'(64);
            z_size_reg    <= SIZE_W'(64);
            radius_reg    <= RAD_W'(1);
            threshold_reg <= THR_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_MODE:      mode_reg      <= cfg_data[0];
                CFG_X_SIZE:    x_size_reg    <= cfg_data[SIZE_W-1:0];
                CFG_Y_SIZE:    y_size_reg    <= cfg_data[SIZE_W-1:0];
                CFG_Z_SIZE:    z_size_reg    <= cfg_data[SIZE_W-1:0];
                CFG_RADIUS:    radius_reg    <= cfg_data[RAD_W-1:0];
                CFG_THRESHOLD: threshold_reg <= cfg_data[THR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Sizes and radius above the built maxima saturate.
    always_comb
    begin
        cfg.mode      = mode_reg;
        cfg.x_size    = (int'(x_size_reg) > MAX_X) ? SIZE_W'(MAX_X) : x_size_reg;
        cfg.y_size    = (int'(y_size_reg) > MAX_Y) ? SIZE_W'(MAX_Y) : y_size_reg;
        cfg.z_size    = (int'(z_size_reg) > MAX_Z) ? SIZE_W'(MAX_Z) : z_size_reg;
        cfg.radius    = (int'(radius_reg) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : radius_reg;
        cfg.threshold = threshold_reg;
    end

    vctm_engine #(
        .MAX_X      (MAX_X),
        .MAX_Y      (MAX_Y),
        .MAX_Z      (MAX_Z),
        .MAX_RADIUS (MAX_RADIUS),
        .AW         (AW)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .start        (start),
        .command      (command),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .voxel_value  (voxel_value),
        .busy         (busy),
        .done         (done),
        .result_value (result_value),
        .mem_req      (mem_req),
        .mem_addr     (mem_addr),
        .mem_rdata    (mem_rdata)
    );

    vctm_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .req   (mem_req),
        .addr  (mem_addr),
        .rdata (mem_rdata)
    );

endmodule

>>> sv/vctm_checker.sv
// ----------------------------------------------------------------------------
// vctm_checker
// Port-level checks on transaction sequencing, bound to the top level.
// ----------------------------------------------------------------------------
module vctm_checker
    import vctm_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic command,
    input logic done
);

    // Busy only rises after a transaction has been taken.
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without an accepted transaction");

    // A write transaction never occupies the block.
    a_write_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (command == CMD_WRITE)) |=> !busy)
        else $error("write transaction made the block busy");

    // A result only follows a period of work and returns the block to idle.
    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) && !busy))
        else $error("result strobe without preceding work");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

endmodule

bind volume_count_threshold_morphology vctm_checker u_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .command (command),
    .done    (done)
);
